[rtl/core/lng_pkg.sv]
// Shared constants, word types and register codes for the lattice neighbor generator.
package lng_pkg;

   localparam int MAX_DIMS        = 4;
   localparam int INDEX_BITS      = 20;
   localparam int SIDE_BITS       = 11;
   localparam int DIMS_BITS       = 3;
   localparam int AXIS_FIELD_BITS = 2;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = SIDE_BITS;

   localparam int AXIS_BITS  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int Q_BITS     = SIDE_BITS;
   localparam int SHIFT_BITS = $clog2(Q_BITS);
   localparam int COUNT_BITS = INDEX_BITS + 1;
   localparam int TRIAL_BITS = COUNT_BITS + Q_BITS;
   localparam int PROD_BITS  = COUNT_BITS + SIDE_BITS;
   localparam int NUM_CELLS  = MAX_DIMS * Q_BITS;

   localparam logic [PROD_BITS-1:0] COUNT_CAP = PROD_BITS'(1) << INDEX_BITS;

   localparam logic [DIMS_BITS-1:0] DIMS_RESET     = DIMS_BITS'(2);
   localparam logic [SIDE_BITS-1:0] SIDE_RESET     = SIDE_BITS'(16);
   localparam logic                 PERIODIC_RESET = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DIMENSIONS  = 2'd0,
      CSR_SIDE_LENGTH = 2'd1,
      CSR_PERIODIC    = 2'd2
   } csr_index_type;

   // One site on its way down the cell row.
   typedef struct packed {
      logic                  err;
      logic [INDEX_BITS-1:0] idx;
      logic [INDEX_BITS-1:0] rem;
      logic [Q_BITS-1:0]     q;
      logic [MAX_DIMS-1:0]   lo;
      logic [MAX_DIMS-1:0]   hi;
   } item_type;

   typedef struct packed {
      logic                  first;
      logic                  last;
      logic [AXIS_BITS-1:0]  axis;
      logic [SHIFT_BITS-1:0] shift;
   } cell_ctl_type;

   typedef struct packed {
      logic                                  busy;
      logic                                  err;
      logic                                  periodic;
      logic [AXIS_BITS-1:0]                  dims_m1;
      logic [SIDE_BITS-1:0]                  side_m1;
      logic [COUNT_BITS-1:0]                 count;
      logic [MAX_DIMS-1:0][COUNT_BITS-1:0]   stride;
      logic [MAX_DIMS-1:0][INDEX_BITS-1:0]   wrap;
   } cfg_type;

endpackage

[rtl/core/lng_cfg.sv]
// Configuration registers and the sequencer that derives strides, wrap offsets and site count.
module lng_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [lng_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lng_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output lng_pkg::cfg_type                    cfg
);

   logic [lng_pkg::DIMS_BITS-1:0]  dims_ff, dims_in;
   logic [lng_pkg::SIDE_BITS-1:0]  side_ff, side_in;
   logic                           periodic_ff, periodic_in;
   logic                           run_ff, run_in;
   logic [lng_pkg::DIMS_BITS-1:0]  t_ff, t_in;
   logic [lng_pkg::COUNT_BITS-1:0] cur_ff, cur_in;
   logic                           ovf_ff, ovf_in;
   logic [lng_pkg::MAX_DIMS-1:0][lng_pkg::COUNT_BITS-1:0] stride_ff, stride_in;
   logic [lng_pkg::MAX_DIMS-1:0][lng_pkg::INDEX_BITS-1:0] wrap_ff, wrap_in;

   logic [lng_pkg::PROD_BITS-1:0]  prod;
   logic [lng_pkg::DIMS_BITS-1:0]  ax_full;
   logic [lng_pkg::AXIS_BITS-1:0]  ax;
   logic                           dims_ok;
   logic                           step_live;

   always_comb begin
      dims_ok   = (dims_ff != '0) && (32'(dims_ff) <= lng_pkg::MAX_DIMS);
      prod      = lng_pkg::PROD_BITS'(cur_ff) * lng_pkg::PROD_BITS'(side_ff);
      ax_full   = dims_ff - t_ff - lng_pkg::DIMS_BITS'(1);
      ax        = ax_full[lng_pkg::AXIS_BITS-1:0];
      step_live = run_ff && dims_ok && (t_ff < dims_ff);

      dims_in     = dims_ff;
      side_in     = side_ff;
      periodic_in = periodic_ff;
      run_in      = run_ff;
      t_in        = t_ff;
      cur_in      = cur_ff;
      ovf_in      = ovf_ff;
      stride_in   = stride_ff;
      wrap_in     = wrap_ff;

      // Walk the axes from the last one (stride 1) up to axis 0.
      if (step_live) begin
         stride_in[ax] = cur_ff;
         wrap_in[ax]   = lng_pkg::INDEX_BITS'(prod - lng_pkg::PROD_BITS'(cur_ff));
         cur_in        = lng_pkg::COUNT_BITS'(prod);
         ovf_in        = ovf_ff | (prod > lng_pkg::COUNT_CAP);
         t_in          = t_ff + lng_pkg::DIMS_BITS'(1);
      end else if (run_ff) begin
         run_in = 1'b0;
      end

      // Any write restarts the derivation.
      if (csr_write_enable) begin
         unique case (csr_index)
            lng_pkg::CSR_DIMENSIONS:  dims_in     = csr_write_data[lng_pkg::DIMS_BITS-1:0];
            lng_pkg::CSR_SIDE_LENGTH: side_in     = csr_write_data[lng_pkg::SIDE_BITS-1:0];
            lng_pkg::CSR_PERIODIC:    periodic_in = csr_write_data[0];
            default: ;
         endcase
         run_in    = 1'b1;
         t_in      = '0;
         cur_in    = lng_pkg::COUNT_BITS'(1);
         ovf_in    = 1'b0;
         stride_in = '0;
         wrap_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff     <= lng_pkg::DIMS_RESET;
         side_ff     <= lng_pkg::SIDE_RESET;
         periodic_ff <= lng_pkg::PERIODIC_RESET;
         run_ff      <= 1'b1;
         t_ff        <= '0;
         cur_ff      <= lng_pkg::COUNT_BITS'(1);
         ovf_ff      <= 1'b0;
         stride_ff   <= '0;
         wrap_ff     <= '0;
      end else begin
         dims_ff     <= dims_in;
         side_ff     <= side_in;
         periodic_ff <= periodic_in;
         run_ff      <= run_in;
         t_ff        <= t_in;
         cur_ff      <= cur_in;
         ovf_ff      <= ovf_in;
         stride_ff   <= stride_in;
         wrap_ff     <= wrap_in;
      end
   end

   always_comb begin
      cfg.busy     = run_ff;
      cfg.err      = !dims_ok || ovf_ff;
      cfg.periodic = periodic_ff;
      cfg.dims_m1  = lng_pkg::AXIS_BITS'(dims_ff - lng_pkg::DIMS_BITS'(1));
      cfg.side_m1  = side_ff - lng_pkg::SIDE_BITS'(1);
      cfg.count    = cur_ff;
      cfg.stride   = stride_ff;
      cfg.wrap     = wrap_ff;
   end

endmodule

[rtl/core/lng_cell.sv]
// One restoring-division cell: a conditional subtract of the shifted stride per cycle while advance is high.
module lng_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  lng_pkg::cell_ctl_type          ctl,
   input  logic [lng_pkg::COUNT_BITS-1:0] stride,
   input  logic [lng_pkg::SIDE_BITS-1:0]  side_m1,
   input  logic                           valid_i,
   input  lng_pkg::item_type              word_i,
   output logic                           valid_o,
   output lng_pkg::item_type              word_o
);

   logic              valid_ff;
   lng_pkg::item_type word_ff, word_in;

   logic [lng_pkg::Q_BITS-1:0]     q_base;
   logic [lng_pkg::TRIAL_BITS-1:0] trial;
   logic                           hit;

   always_comb begin
      q_base  = ctl.first ? '0 : word_i.q;
      trial   = lng_pkg::TRIAL_BITS'(stride) << ctl.shift;
      hit     = lng_pkg::TRIAL_BITS'(word_i.rem) >= trial;
      word_in = word_i;
      if (hit) begin
         word_in.rem = word_i.rem - trial[lng_pkg::INDEX_BITS-1:0];
      end
      word_in.q = {q_base[lng_pkg::Q_BITS-2:0], hit};
      // Coordinate is complete: record whether it sits on either edge.
      if (ctl.last) begin
         word_in.lo[ctl.axis] = (word_in.q == '0);
         word_in.hi[ctl.axis] = (word_in.q == side_m1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign valid_o = valid_ff;
   assign word_o  = word_ff;

endmodule

[rtl/core/lng_expand.sv]
// Result serializer: turns one decoded site into its neighbor words and holds the output register.
module lng_expand (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lng_pkg::cfg_type                     cfg,
   input  logic                                 tail_valid,
   input  lng_pkg::item_type                    tail_word,
   output logic                                 take,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [lng_pkg::INDEX_BITS-1:0]       rsp_neighbor_index,
   output logic [lng_pkg::AXIS_FIELD_BITS-1:0]  rsp_axis,
   output logic                                 rsp_toward_lower,
   output logic                                 rsp_present,
   output logic                                 rsp_site_error,
   output logic                                 rsp_last
);

   logic                          exp_valid_ff, exp_valid_in;
   lng_pkg::item_type             word_ff;
   logic [lng_pkg::AXIS_BITS:0]   cnt_ff, cnt_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [lng_pkg::INDEX_BITS-1:0]       rsp_neighbor_index_ff, rsp_neighbor_index_in;
   logic [lng_pkg::AXIS_FIELD_BITS-1:0]  rsp_axis_ff, rsp_axis_in;
   logic                                 rsp_toward_lower_ff, rsp_toward_lower_in;
   logic                                 rsp_present_ff, rsp_present_in;
   logic                                 rsp_site_error_ff, rsp_site_error_in;
   logic                                 rsp_last_ff, rsp_last_in;

   logic [lng_pkg::AXIS_BITS-1:0]  ax;
   logic                           down;
   logic                           is_final;
   logic                           out_ready;
   logic                           emit;
   logic                           at_edge;
   logic                           sub;
   logic                           cut;
   logic [lng_pkg::INDEX_BITS-1:0] mag;
   logic [lng_pkg::INDEX_BITS-1:0] sum;

   always_comb begin
      ax        = cnt_ff[lng_pkg::AXIS_BITS:1];
      down      = cnt_ff[0];
      is_final  = word_ff.err || ((ax == cfg.dims_m1) && down);
      out_ready = !rsp_valid_ff || !rsp_stall;
      emit      = exp_valid_ff && out_ready;
      take      = !exp_valid_ff || (emit && is_final);

      // An edge step uses the wrap offset in the opposite direction.
      at_edge = down ? word_ff.lo[ax] : word_ff.hi[ax];
      mag     = at_edge ? cfg.wrap[ax] : cfg.stride[ax][lng_pkg::INDEX_BITS-1:0];
      sub     = down ^ at_edge;
      sum     = sub ? (word_ff.idx - mag) : (word_ff.idx + mag);
      cut     = at_edge && !cfg.periodic;

      exp_valid_in = take ? tail_valid : exp_valid_ff;
      if (take) begin
         cnt_in = '0;
      end else if (emit) begin
         cnt_in = cnt_ff + (lng_pkg::AXIS_BITS + 1)'(1);
      end else begin
         cnt_in = cnt_ff;
      end

      rsp_valid_in          = emit || (rsp_valid_ff && rsp_stall);
      rsp_neighbor_index_in = rsp_neighbor_index_ff;
      rsp_axis_in           = rsp_axis_ff;
      rsp_toward_lower_in   = rsp_toward_lower_ff;
      rsp_present_in        = rsp_present_ff;
      rsp_site_error_in     = rsp_site_error_ff;
      rsp_last_in           = rsp_last_ff;
      if (emit) begin
         if (word_ff.err) begin
            rsp_neighbor_index_in = '0;
            rsp_axis_in           = '0;
            rsp_toward_lower_in   = 1'b0;
            rsp_present_in        = 1'b0;
            rsp_site_error_in     = 1'b1;
            rsp_last_in           = 1'b1;
         end else begin
            rsp_neighbor_index_in = cut ? '0 : sum;
            rsp_axis_in           = lng_pkg::AXIS_FIELD_BITS'(ax);
            rsp_toward_lower_in   = down;
            rsp_present_in        = !cut;
            rsp_site_error_in     = 1'b0;
            rsp_last_in           = is_final;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         exp_valid_ff <= exp_valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= tail_word;
      end
      rsp_neighbor_index_ff <= rsp_neighbor_index_in;
      rsp_axis_ff           <= rsp_axis_in;
      rsp_toward_lower_ff   <= rsp_toward_lower_in;
      rsp_present_ff        <= rsp_present_in;
      rsp_site_error_ff     <= rsp_site_error_in;
      rsp_last_ff           <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neighbor_index = rsp_neighbor_index_ff;
   assign rsp_axis           = rsp_axis_ff;
   assign rsp_toward_lower   = rsp_toward_lower_ff;
   assign rsp_present        = rsp_present_ff;
   assign rsp_site_error     = rsp_site_error_ff;
   assign rsp_last           = rsp_last_ff;

   a_err_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_site_error_ff |-> rsp_last_ff && !rsp_present_ff)
      else $error("error word must be a single absent last word");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_present_ff |-> rsp_neighbor_index_ff == '0)
      else $error("absent neighbor must carry index zero");

   a_err_one_word: assert property (@(posedge clock) disable iff (reset)
      exp_valid_ff && word_ff.err |-> cnt_ff == '0)
      else $error("error site advanced past its only word");

   a_free_after_last: assert property (@(posedge clock) disable iff (reset)
      emit && is_final && !tail_valid |=> !exp_valid_ff)
      else $error("serializer still busy after last word of a site");

endmodule

[rtl/core/lattice_neighbor_generator_unit.sv]
// Path: an accepted site word crosses 44 cells and 2 stages, the serializer and the output register.
// Output: 2*dimensions result words per site, one per cycle while rsp_stall is low; error sites give one.
// The single result serializer limits the site rate; the cell row itself takes a site every cycle it is not held.
// Reset: registers return to dimensions 2, side length 16, periodic; strides are then derived
// with req_stall high, and the same settle follows every csr write.
module lattice_neighbor_generator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lng_pkg::INDEX_BITS-1:0]       req_site_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lng_pkg::INDEX_BITS-1:0]       rsp_neighbor_index,
   output logic [lng_pkg::AXIS_FIELD_BITS-1:0]  rsp_axis,
   output logic                                 rsp_toward_lower,
   output logic                                 rsp_present,
   output logic                                 rsp_site_error,
   output logic                                 rsp_last,
   input  logic                                 csr_write_enable,
   input  logic [lng_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lng_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   lng_pkg::cfg_type  cfg;

   // Stage 0 is the incoming word; stage j+1 is the output of cell j.
   logic [lng_pkg::NUM_CELLS:0] stage_valid;
   lng_pkg::item_type           stage_word [lng_pkg::NUM_CELLS+1];

   logic advance;
   logic take;

   lng_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Hold the whole row when the tail word cannot move into the serializer.
   assign advance   = !stage_valid[lng_pkg::NUM_CELLS] || take;
   assign req_stall = cfg.busy || csr_write_enable || !advance;

   // Head word: the remainder starts as the site index; flag out-of-range sites here.
   always_comb begin
      stage_valid[0]    = req_valid && !cfg.busy && !csr_write_enable;
      stage_word[0].idx = req_site_index;
      stage_word[0].rem = req_site_index;
      stage_word[0].q   = '0;
      stage_word[0].lo  = '0;
      stage_word[0].hi  = '0;
      stage_word[0].err = cfg.err || ({1'b0, req_site_index} >= cfg.count);
   end

   // Each axis owns Q_BITS cells, most significant quotient bit first, axis 0 first.
   for (genvar j = 0; j < lng_pkg::NUM_CELLS; j++) begin : g_cell
      localparam int AxisPos = j / lng_pkg::Q_BITS;
      localparam int BitPos  = lng_pkg::Q_BITS - 1 - (j % lng_pkg::Q_BITS);

      lng_pkg::cell_ctl_type cell_ctl;

      assign cell_ctl.first = (BitPos == lng_pkg::Q_BITS - 1);
      assign cell_ctl.last  = (BitPos == 0);
      assign cell_ctl.axis  = lng_pkg::AXIS_BITS'(AxisPos);
      assign cell_ctl.shift = lng_pkg::SHIFT_BITS'(BitPos);

      lng_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl     (cell_ctl),
         .stride  (cfg.stride[AxisPos]),
         .side_m1 (cfg.side_m1),
         .valid_i (stage_valid[j]),
         .word_i  (stage_word[j]),
         .valid_o (stage_valid[j+1]),
         .word_o  (stage_word[j+1])
      );
   end

   // Serialize each decoded site into its up/down neighbor words behind an output register.
   lng_expand u_expand (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .tail_valid         (stage_valid[lng_pkg::NUM_CELLS]),
      .tail_word          (stage_word[lng_pkg::NUM_CELLS]),
      .take               (take),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_axis           (rsp_axis),
      .rsp_toward_lower   (rsp_toward_lower),
      .rsp_present        (rsp_present),
      .rsp_site_error     (rsp_site_error),
      .rsp_last           (rsp_last)
   );

endmodule

[bench/lattice_neighbor_checker.sv]
// Scoreboard for the lattice neighbor generator: predicts neighbor words and compares them.
module lattice_neighbor_checker
   import lng_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [INDEX_BITS-1:0]        req_site_index,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [INDEX_BITS-1:0]        rsp_neighbor_index,
   input  logic [AXIS_FIELD_BITS-1:0]   rsp_axis,
   input  logic                         rsp_toward_lower,
   input  logic                         rsp_present,
   input  logic                         rsp_site_error,
   input  logic                         rsp_last,
   input  logic                         csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_write_data,
   output int                           fault_count,
   output int                           pending
);

   localparam longint unsigned SITE_CAP = 64'd1 << INDEX_BITS;

   typedef struct packed {
      logic [INDEX_BITS-1:0]      neighbor_index;
      logic [AXIS_FIELD_BITS-1:0] axis;
      logic                       toward_lower;
      logic                       present;
      logic                       site_error;
      logic                       last;
   } neighbor_word_type;

   logic [DIMS_BITS-1:0] dims_q;
   logic [SIDE_BITS-1:0] side_q;
   logic                 periodic_q;

   neighbor_word_type expected_words [$];
   neighbor_word_type got_word;
   neighbor_word_type want_word;

   // Append one predicted word behind the ones already waiting.
   function automatic void queue_word(input neighbor_word_type w);
      expected_words = {expected_words, w};
   endfunction

   // Split the site into coordinates and queue its up/down neighbors, axis 0 first.
   function automatic void expand_site(input logic [INDEX_BITS-1:0] site);
      longint unsigned here, span, sites, s, coord;
      longint unsigned strides [MAX_DIMS];
      int d, i;
      bit bad;
      neighbor_word_type w;
      here  = 64'(site);
      span  = 64'(side_q);
      d     = int'(dims_q);
      sites = 1;
      bad   = 1'b0;
      if (d == 0 || d > MAX_DIMS) begin
         bad = 1'b1;
      end else begin
         for (i = 0; i < d && !bad; i++) begin
            sites = sites * span;
            if (sites > SITE_CAP) bad = 1'b1;
         end
         if (!bad && here >= sites) bad = 1'b1;
      end
      if (bad) begin
         w = '0;
         w.site_error = 1'b1;
         w.last = 1'b1;
         queue_word(w);
         return;
      end
      strides[d-1] = 1;
      for (i = d - 2; i >= 0; i--) strides[i] = strides[i+1] * span;
      for (i = 0; i < d; i++) begin
         s = strides[i];
         coord = (here / s) % span;
         w = '0;
         w.axis = AXIS_FIELD_BITS'(i);
         if (coord < span - 1) begin
            w.neighbor_index = INDEX_BITS'(here + s);
            w.present = 1'b1;
         end else if (periodic_q) begin
            w.neighbor_index = INDEX_BITS'(here - (span - 1) * s);
            w.present = 1'b1;
         end
         queue_word(w);
         w = '0;
         w.axis = AXIS_FIELD_BITS'(i);
         w.toward_lower = 1'b1;
         w.last = (i == d - 1);
         if (coord > 0) begin
            w.neighbor_index = INDEX_BITS'(here - s);
            w.present = 1'b1;
         end else if (periodic_q) begin
            w.neighbor_index = INDEX_BITS'(here + (span - 1) * s);
            w.present = 1'b1;
         end
         queue_word(w);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         dims_q      <= DIMS_RESET;
         side_q      <= SIDE_RESET;
         periodic_q  <= PERIODIC_RESET;
         fault_count <= 0;
         pending     <= 0;
         expected_words.delete();
      end else begin
         // Check results before queuing new ones, so a stray word never matches
         // this edge's site.
         if (rsp_valid && !rsp_stall) begin
            got_word = {rsp_neighbor_index, rsp_axis, rsp_toward_lower,
                        rsp_present, rsp_site_error, rsp_last};
            if (expected_words.size() == 0) begin
               if (fault_count < 10)
                  $display({"unexpected neighbor word: idx %h axis %0d low %0b",
                            " pres %0b err %0b last %0b"},
                           got_word.neighbor_index, got_word.axis, got_word.toward_lower,
                           got_word.present, got_word.site_error, got_word.last);
               fault_count <= fault_count + 1;
            end else begin
               want_word = expected_words.pop_front();
               if (got_word !== want_word) begin
                  if (fault_count < 10) begin
                     $display({"neighbor word mismatch: expected idx %h axis %0d low %0b",
                               " pres %0b err %0b last %0b"},
                              want_word.neighbor_index, want_word.axis,
                              want_word.toward_lower, want_word.present,
                              want_word.site_error, want_word.last);
                     $display({"                        actual   idx %h axis %0d low %0b",
                               " pres %0b err %0b last %0b"},
                              got_word.neighbor_index, got_word.axis,
                              got_word.toward_lower, got_word.present,
                              got_word.site_error, got_word.last);
                  end
                  fault_count <= fault_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) expand_site(req_site_index);
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DIMENSIONS:  dims_q     <= csr_write_data[DIMS_BITS-1:0];
               CSR_SIDE_LENGTH: side_q     <= csr_write_data[SIDE_BITS-1:0];
               CSR_PERIODIC:    periodic_q <= csr_write_data[0];
               default: ;
            endcase
         end
         pending <= expected_words.size();
      end
   end

endmodule

[bench/lattice_neighbor_generator_unit_tb.sv]
// Testbench top for the lattice neighbor generator: site stimulus, settings, stalls and verdict.
module lattice_neighbor_generator_unit_tb;
   import lng_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_PHASES  = 7;
   localparam int HOLDOFF_PHASE  = 4;
   localparam int PAUSE_PHASE    = 5;
   localparam int HOLDOFF_CYCLES = 600;
   localparam int SETTLE_CYCLES  = 60;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam longint unsigned SITE_CAP = 64'd1 << INDEX_BITS;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [INDEX_BITS-1:0]       req_site_index = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [INDEX_BITS-1:0]       rsp_neighbor_index;
   logic [AXIS_FIELD_BITS-1:0]  rsp_axis;
   logic                        rsp_toward_lower;
   logic                        rsp_present;
   logic                        rsp_site_error;
   logic                        rsp_last;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_write_data = '0;

   idle_mode_type idle_mode = IDLE_NONE;
   int         phase_no = -1;
   int         hold_left = 0;
   bit         hold_spent = 1'b0;
   int         cycle_count = 0;
   int         fault_count;
   int         pending_words;

   lattice_neighbor_generator_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_site_index     (req_site_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_axis           (rsp_axis),
      .rsp_toward_lower   (rsp_toward_lower),
      .rsp_present        (rsp_present),
      .rsp_site_error     (rsp_site_error),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   lattice_neighbor_checker neighbor_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_site_index     (req_site_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_axis           (rsp_axis),
      .rsp_toward_lower   (rsp_toward_lower),
      .rsp_present        (rsp_present),
      .rsp_site_error     (rsp_site_error),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .fault_count        (fault_count),
      .pending            (pending_words)
   );

   always #5 clock = ~clock;

   // Bound the run; a hung handshake lands here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending_words);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int sender_idle_pct(input idle_mode_type m);
      case (m)
         IDLE_SENDER: return 77;
         IDLE_BOTH:   return 13;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(input idle_mode_type m);
      case (m)
         IDLE_RECEIVER: return 77;
         IDLE_BOTH:     return 13;
         default:       return 0;
      endcase
   endfunction

   // Receiver side. Once, at the hold-off phase, hold stall high for a long stretch so the
   // cell row fills and the block pushes back on the site channel; otherwise stall at random.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (phase_no == HOLDOFF_PHASE && !hold_spent) begin
         rsp_stall  <= 1'b1;
         hold_spent <= 1'b1;
         hold_left  <= HOLDOFF_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct(idle_mode));
      end
   end

   // Offer one site word and hold it until the block takes it. Returns at the accepting edge,
   // so the caller may present the next word in the same step without a bubble.
   task automatic send_site(input logic [INDEX_BITS-1:0] site);
      if ($urandom_range(99) < sender_idle_pct(idle_mode)) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct(idle_mode));
      end
      req_valid      <= 1'b1;
      req_site_index <= site;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every predicted word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // Reprogram the lattice only once the block is idle. Unused data bits get junk so the
   // register masking is exercised, and the spare index takes a write that must be ignored.
   task automatic reconfigure(input int dims, input int side, input int per);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = CSR_DATA_BITS'($urandom());
      drain_results();
      csr_put(CSR_SPARE, CSR_DATA_BITS'($urandom()));
      csr_put(CSR_DIMENSIONS, {junk[CSR_DATA_BITS-1:DIMS_BITS], DIMS_BITS'(dims)});
      csr_put(CSR_SIDE_LENGTH, CSR_DATA_BITS'(side));
      csr_put(CSR_PERIODIC, {junk[CSR_DATA_BITS-1:1], 1'(per)});
      csr_write_enable <= 1'b0;
   endtask

   // Site count of a usable lattice, zero when the settings give only error words.
   function automatic longint unsigned lattice_sites(input int dims, input int side);
      longint unsigned total;
      int i;
      if (dims < 1 || dims > MAX_DIMS) return 0;
      total = 1;
      for (i = 0; i < dims; i++) total = total * side;
      return (total > SITE_CAP) ? 0 : total;
   endfunction

   // Mostly in-range sites, a good share built from edge coordinates, and some past the end.
   function automatic logic [INDEX_BITS-1:0] random_site(input int dims, input int side);
      longint unsigned total, site;
      int roll, i, c;
      total = lattice_sites(dims, side);
      roll  = $urandom_range(99);
      if (total == 0 || roll < 8) return INDEX_BITS'($urandom());
      if (roll < 16) begin
         site = total + $urandom_range(3);
         return (site >= SITE_CAP) ? INDEX_BITS'($urandom()) : INDEX_BITS'(site);
      end
      if (roll < 50) begin
         site = 0;
         for (i = 0; i < dims; i++) begin
            case ($urandom_range(2))
               0:       c = 0;
               1:       c = side - 1;
               default: c = $urandom_range(side - 1);
            endcase
            site = site * side + c;
         end
         return INDEX_BITS'(site);
      end
      return INDEX_BITS'($urandom_range(32'(total - 1)));
   endfunction

   initial begin : stimulus
      int dims, side, per, roll, count, p, k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: 16x16 periodic. Corners, edges, interior, one past the end, all ones.
      send_site(20'd0);
      send_site(20'd15);
      send_site(20'd16);
      send_site(20'd17);
      send_site(20'd240);
      send_site(20'd255);
      send_site(20'd256);
      send_site(20'hFFFFF);
      // One axis of side two, open edges.
      reconfigure(1, 2, 0);
      send_site(20'd0);
      send_site(20'd1);
      send_site(20'd2);
      // Site count exactly at capacity, four axes.
      reconfigure(4, 32, 1);
      send_site(20'd0);
      send_site(20'hFFFFF);
      send_site(20'h84210);
      reconfigure(2, 1024, 0);
      send_site(20'd0);
      send_site(20'd1023);
      send_site(20'hFFFFF);
      // Side length one: both steps wrap onto the site itself, or both are cut.
      reconfigure(3, 1, 1);
      send_site(20'd0);
      send_site(20'd1);
      reconfigure(2, 1, 0);
      send_site(20'd0);
      // Lattices that only ever give the error word.
      reconfigure(0, 16, 1);
      send_site(20'd5);
      reconfigure(7, 2, 1);
      send_site(20'd0);
      reconfigure(2, 0, 1);
      send_site(20'd0);
      reconfigure(2, 2047, 0);
      send_site(20'd0);
      reconfigure(4, 33, 1);
      send_site(20'd0);

      // Random lattices, one idling pattern per phase.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p == HOLDOFF_PHASE) begin
            dims = 3;
            side = $urandom_range(2, 6);
         end else begin
            roll = $urandom_range(99);
            if (roll < 10) dims = (roll < 3) ? 0 : $urandom_range(5, 7);
            else           dims = $urandom_range(1, MAX_DIMS);
            roll = $urandom_range(99);
            if (roll < 10)      side = $urandom_range(2047);
            else if (roll < 25) side = $urandom_range(1, 2);
            else begin
               case (dims)
                  3:       side = $urandom_range(2, 101);
                  4:       side = $urandom_range(2, 32);
                  default: side = $urandom_range(2, 1024);
               endcase
            end
         end
         per = $urandom_range(1);
         reconfigure(dims, side, per);
         idle_mode <= idle_mode_type'(p % 4);
         phase_no  <= p;
         // The hold-off phase offers enough words back to back to fill the block.
         count = (p == HOLDOFF_PHASE) ? 50 : 6;
         for (k = 0; k < count; k++) begin
            if (p == PAUSE_PHASE && k == count / 2) drain_results();
            send_site(random_site(dims, side));
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_words == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
